>>> sv/srrm_pkg.sv
// srrm_pkg: shared constants, field widths and record types of the solid run rectangle merger
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package srrm_pkg;

    localparam int DEF_MAX_COLUMNS    = 64;
    localparam int DEF_ROW_INDEX_BITS = 16;
    localparam int ROW_SOLID_W        = 64;
    localparam int ROW_WIDTH_W        = 7;
    localparam int COL_OUT_W          = 6;
    localparam int ROW_OUT_W          = 16;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(64);

    // per column flags found by one lane
    typedef struct packed {
        logic ps;
        logic pe;
        logic cs;
        logic ce;
        logic x;
    } t_lane_flags;

    typedef struct packed {
        logic [COL_OUT_W-1:0] box_left;
        logic [COL_OUT_W-1:0] box_right;
        logic [ROW_OUT_W-1:0] box_top;
        logic [ROW_OUT_W-1:0] box_bottom;
        logic                 last_box;
    } t_box;

endpackage

`default_nettype wire

>>> sv/srrm_if.sv
// srrm_if: valid/ready channel interfaces for configuration, input rows and output boxes
// depends on srrm_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface srrm_cfg_if import srrm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ROW_WIDTH_W-1:0] row_width;

    modport source (output valid, output row_width, input ready);
    modport sink (input valid, input row_width, output ready);
endinterface

interface srrm_row_if import srrm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ROW_SOLID_W-1:0] row_solid;
    logic                   last_row;

    modport source (output valid, output row_solid, output last_row, input ready);
    modport sink (input valid, input row_solid, input last_row, output ready);
endinterface

interface srrm_box_if import srrm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] box_left;
    logic [COL_OUT_W-1:0] box_right;
    logic [ROW_OUT_W-1:0] box_top;
    logic [ROW_OUT_W-1:0] box_bottom;
    logic                 last_box;

    modport source (output valid, output box_left, output box_right, output box_top,
                    output box_bottom, output last_box, input ready);
    modport sink (input valid, input box_left, input box_right, input box_top,
                  input box_bottom, input last_box, output ready);
endinterface

`default_nettype wire

>>> sv/srrm_lane.sv
// srrm_lane: one column lane, finds run starts, run ends and mismatches against the previous row
// depends on srrm_pkg for t_lane_flags
`timescale 1ns / 1ps
`default_nettype none

module srrm_lane import srrm_pkg::*; (
    input  wire logic [2:0]  i_prev,
    input  wire logic [2:0]  i_cur,
    output t_lane_flags      o_flags
);

    // bit 0 is the column to the left, bit 1 this column, bit 2 the column to the right
    logic ps;
    logic pe;
    logic cs;
    logic ce;

    assign ps = i_prev[1] & ~i_prev[0];
    assign pe = i_prev[1] & ~i_prev[2];
    assign cs = i_cur[1] & ~i_cur[0];
    assign ce = i_cur[1] & ~i_cur[2];

    assign o_flags.ps = ps;
    assign o_flags.pe = pe;
    assign o_flags.cs = cs;
    assign o_flags.ce = ce;
    // previous run broken here: own bit differs, or a bounding neighbor differs
    assign o_flags.x  = i_prev[1] & ((i_prev[1] ^ i_cur[1])
                                   | (ps & (i_prev[0] ^ i_cur[0]))
                                   | (pe & (i_prev[2] ^ i_cur[2])));

endmodule

`default_nettype wire

>>> sv/srrm_merge.sv
// srrm_merge: merging sequencer, walks lane flags run by run, keeps box top rows, emits boxes
// depends on srrm_pkg and srrm_box_if
`timescale 1ns / 1ps
`default_nettype none

module srrm_merge import srrm_pkg::*; #(
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
    parameter int ROW_INDEX_BITS = DEF_ROW_INDEX_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_last,
    input  wire t_lane_flags               i_flags [MAX_COLUMNS],
    input  wire logic [ROW_INDEX_BITS-1:0] i_step_idx,
    input  wire logic [ROW_INDEX_BITS-1:0] i_step_pidx,
    output logic                           o_idle,
    srrm_box_if.source                     o_box
);

    localparam int MC = MAX_COLUMNS;
    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RB = ROW_INDEX_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_OPEN  = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

    function automatic logic [CW-1:0] f_low(input logic [MC-1:0] v);
        logic [CW-1:0] r;
        r = '0;
        for (int i = MC - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = CW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [MC-1:0] f_le(input logic [CW-1:0] e);
        logic [MC-1:0] m;
        for (int i = 0; i < MC; i++) begin
            m[i] = (CW'(i) <= e);
        end
        return m;
    endfunction

    function automatic logic [MC-1:0] f_dec(input logic [CW-1:0] s);
        logic [MC-1:0] m;
        for (int i = 0; i < MC; i++) begin
            m[i] = (CW'(i) == s);
        end
        return m;
    endfunction

    t_state        r_state, n_state;
    logic [MC-1:0] r_ps_rem, n_ps_rem;
    logic [MC-1:0] r_pe_rem, n_pe_rem;
    logic [MC-1:0] r_x_rem, n_x_rem;
    logic [MC-1:0] r_cs_rem, n_cs_rem;
    logic [MC-1:0] r_ce_rem, n_ce_rem;
    logic [MC-1:0] r_cont, n_cont;
    logic          r_last, n_last;
    logic [RB-1:0] r_step_idx, n_step_idx;
    logic [RB-1:0] r_step_pidx, n_step_pidx;
    logic [CW-1:0] r_pend_l, n_pend_l;
    logic [CW-1:0] r_pend_r, n_pend_r;
    logic [RB-1:0] r_pend_bot, n_pend_bot;
    logic          r_use_idx, n_use_idx;
    logic          r_from_open, n_from_open;
    t_box          r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    t_box          r_out, n_out;
    logic          r_out_v, n_out_v;

    logic [RB-1:0] mem [MC];
    logic [RB-1:0] r_rd_data;
    logic [CW-1:0] rd_addr;
    logic          mem_we;

    logic [MC-1:0] f_ps, f_pe, f_cs, f_ce, f_x;
    logic [CW-1:0] sc_s, sc_e;
    logic [MC-1:0] sc_le;
    logic          sc_closed;
    logic [MC-1:0] open_set;
    logic [CW-1:0] op_s, op_e;
    logic          op_new;
    logic          out_free;
    t_box          fetch_box;
    t_state        fetch_ret;

    always_comb begin
        for (int c = 0; c < MC; c++) begin
            f_ps[c] = i_flags[c].ps;
            f_pe[c] = i_flags[c].pe;
            f_cs[c] = i_flags[c].cs;
            f_ce[c] = i_flags[c].ce;
            f_x[c]  = i_flags[c].x;
        end
    end

    // lowest open previous run and whether this row breaks it
    assign sc_s      = f_low(r_ps_rem);
    assign sc_e      = f_low(r_pe_rem);
    assign sc_le     = f_le(sc_e);
    assign sc_closed = |(r_x_rem & sc_le);

    // current runs to open, or all current runs on the last row
    assign open_set = r_cs_rem & (r_last ? {MC{1'b1}} : ~r_cont);
    assign op_s     = f_low(open_set);
    assign op_e     = f_low(r_ce_rem);
    assign op_new   = ~r_cont[op_s];

    assign out_free  = ~r_out_v | o_box.ready;
    assign fetch_ret = r_from_open ? ST_OPEN : ST_SCAN;

    always_comb begin
        fetch_box.box_left   = COL_OUT_W'(r_pend_l);
        fetch_box.box_right  = COL_OUT_W'(r_pend_r);
        fetch_box.box_top    = r_use_idx ? ROW_OUT_W'(r_step_idx) : ROW_OUT_W'(r_rd_data);
        fetch_box.box_bottom = ROW_OUT_W'(r_pend_bot);
        fetch_box.last_box   = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_ps_rem    = r_ps_rem;
        n_pe_rem    = r_pe_rem;
        n_x_rem     = r_x_rem;
        n_cs_rem    = r_cs_rem;
        n_ce_rem    = r_ce_rem;
        n_cont      = r_cont;
        n_last      = r_last;
        n_step_idx  = r_step_idx;
        n_step_pidx = r_step_pidx;
        n_pend_l    = r_pend_l;
        n_pend_r    = r_pend_r;
        n_pend_bot  = r_pend_bot;
        n_use_idx   = r_use_idx;
        n_from_open = r_from_open;
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_out       = r_out;
        n_out_v     = r_out_v & ~o_box.ready;
        mem_we      = 1'b0;
        rd_addr     = r_pend_l;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_ps_rem    = f_ps;
                    n_pe_rem    = f_pe;
                    n_x_rem     = f_x;
                    n_cs_rem    = f_cs;
                    n_ce_rem    = f_ce;
                    n_cont      = '0;
                    n_last      = i_last;
                    n_step_idx  = i_step_idx;
                    n_step_pidx = i_step_pidx;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_addr = sc_s;
                if (r_ps_rem == '0) begin
                    n_state = ST_OPEN;
                end else begin
                    n_ps_rem = r_ps_rem & ~sc_le;
                    n_pe_rem = r_pe_rem & ~sc_le;
                    n_x_rem  = r_x_rem & ~sc_le;
                    if (sc_closed) begin
                        n_pend_l    = sc_s;
                        n_pend_r    = sc_e;
                        n_pend_bot  = r_step_pidx;
                        n_use_idx   = 1'b0;
                        n_from_open = 1'b0;
                        n_state     = ST_FETCH;
                    end else begin
                        n_cont = r_cont | f_dec(sc_s);
                    end
                end
            end
            ST_FETCH: begin
                if (!r_hold_v) begin
                    n_hold   = fetch_box;
                    n_hold_v = 1'b1;
                    n_state  = fetch_ret;
                end else if (out_free) begin
                    n_out   = r_hold;
                    n_out_v = 1'b1;
                    n_hold  = fetch_box;
                    n_state = fetch_ret;
                end
            end
            ST_OPEN: begin
                rd_addr = op_s;
                if (open_set == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    mem_we   = op_new;
                    n_cs_rem = r_cs_rem & ~f_dec(op_s);
                    if (r_last) begin
                        n_ce_rem    = r_ce_rem & ~f_le(op_e);
                        n_pend_l    = op_s;
                        n_pend_r    = op_e;
                        n_pend_bot  = r_step_idx;
                        n_use_idx   = op_new;
                        n_from_open = 1'b1;
                        n_state     = ST_FETCH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out          = r_hold;
                    n_out.last_box = 1'b1;
                    n_out_v        = 1'b1;
                    n_hold_v       = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[op_s] <= r_step_idx;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ps_rem    <= n_ps_rem;
        r_pe_rem    <= n_pe_rem;
        r_x_rem     <= n_x_rem;
        r_cs_rem    <= n_cs_rem;
        r_ce_rem    <= n_ce_rem;
        r_cont      <= n_cont;
        r_last      <= n_last;
        r_step_idx  <= n_step_idx;
        r_step_pidx <= n_step_pidx;
        r_pend_l    <= n_pend_l;
        r_pend_r    <= n_pend_r;
        r_pend_bot  <= n_pend_bot;
        r_use_idx   <= n_use_idx;
        r_from_open <= n_from_open;
        r_hold      <= n_hold;
        r_out       <= n_out;
    end

    assign o_idle           = (r_state == ST_IDLE);
    assign o_box.valid      = r_out_v;
    assign o_box.box_left   = r_out.box_left;
    assign o_box.box_right  = r_out.box_right;
    assign o_box.box_top    = r_out.box_top;
    assign o_box.box_bottom = r_out.box_bottom;
    assign o_box.last_box   = r_out.last_box;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("merge state not one-hot");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_hold_v)
        else $error("held box left behind at end of row");

    a_open_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OPEN |-> r_ps_rem == '0)
        else $error("open phase entered with previous runs pending");

    a_flush_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_hold_v && out_free) |=> (!r_hold_v && r_out_v && r_out.last_box))
        else $error("final box of row not marked");

endmodule

`default_nettype wire

>>> sv/solid_run_rectangle_merger_top.sv
// Solid run rectangle merger. Each accepted request is one row of solid flags, masked to the
// configured row width; one lane per column finds run edges and mismatches against the previous
// row in the accept cycle, then a merging sequencer walks the runs one per cycle, apart from a
// fetch step for each box it emits and stalls while the output register is full. A row passes
// through these steps: accept, the runs of the previous row and the end of that scan, a fetch
// for each box it closes (with the top-row memory read), the runs that open a new box (one
// top-row memory write each; on the last row every run of the row), a fetch for each box
// emitted on the last row, the end of the open pass and the hand-over of the final box. The
// top-row memory has one write and one read port; it needs no clearing pass after reset. A new
// row is accepted only once the previous one is fully handled.
// depends on srrm_pkg, srrm_if, srrm_lane and srrm_merge
`timescale 1ns / 1ps
`default_nettype none

module solid_run_rectangle_merger_top import srrm_pkg::*; #(
    parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
    parameter int ROW_INDEX_BITS = DEF_ROW_INDEX_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srrm_cfg_if.sink   i_cfg,
    srrm_row_if.sink   i_row,
    srrm_box_if.source o_box
);

    localparam int MC = MAX_COLUMNS;
    localparam int RB = ROW_INDEX_BITS;

    logic [ROW_WIDTH_W-1:0] r_row_width;
    logic [MC-1:0]          r_prev, n_prev;
    logic [RB-1:0]          r_prev_idx, n_prev_idx;
    logic [RB-1:0]          r_idx, n_idx;

    logic [MC-1:0]   width_mask;
    logic [MC-1:0]   cur;
    logic [MC+1:0]   prev_pad;
    logic [MC+1:0]   cur_pad;
    t_lane_flags     flags [MC];
    logic            merge_idle;
    logic            row_accept;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_row_width <= i_cfg.row_width;
        end
    end

    // widths above the column count saturate by construction
    always_comb begin
        for (int c = 0; c < MC; c++) begin
            width_mask[c] = (ROW_WIDTH_W'(c) < r_row_width);
        end
    end

    assign cur      = i_row.row_solid[MC-1:0] & width_mask;
    assign prev_pad = {1'b0, r_prev, 1'b0};
    assign cur_pad  = {1'b0, cur, 1'b0};

    genvar g;
    generate
        for (g = 0; g < MC; g++) begin : g_lane
            srrm_lane u_lane (
                .i_prev  (prev_pad[g+2:g]),
                .i_cur   (cur_pad[g+2:g]),
                .o_flags (flags[g])
            );
        end
    endgenerate

    assign i_row.ready = merge_idle;
    assign row_accept  = i_row.valid & merge_idle;

    always_comb begin
        n_prev     = r_prev;
        n_prev_idx = r_prev_idx;
        n_idx      = r_idx;
        if (row_accept) begin
            if (i_row.last_row) begin
                n_prev     = '0;
                n_prev_idx = '0;
                n_idx      = '0;
            end else begin
                n_prev     = cur;
                n_prev_idx = r_idx;
                n_idx      = (&r_idx) ? r_idx : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_prev_idx <= '0;
            r_idx      <= '0;
        end else begin
            r_prev     <= n_prev;
            r_prev_idx <= n_prev_idx;
            r_idx      <= n_idx;
        end
    end

    srrm_merge #(
        .MAX_COLUMNS    (MAX_COLUMNS),
        .ROW_INDEX_BITS (ROW_INDEX_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (row_accept),
        .i_last      (i_row.last_row),
        .i_flags     (flags),
        .i_step_idx  (r_idx),
        .i_step_pidx (r_prev_idx),
        .o_idle      (merge_idle),
        .o_box       (o_box)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// testbench for solid_run_rectangle_merger_top: drives rows of solid flags, predicts the merged
// boxes in step with each accepted request and checks every box that leaves the block
// depends on srrm_pkg, srrm_if and the block's rtl
`timescale 1ns / 1ps

module testbench;
    import srrm_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic [ROW_OUT_W-1:0]   ROW_INDEX_TOP = '1;
    localparam logic [ROW_SOLID_W-1:0] ALL_SOLID     = '1;
    localparam logic [ROW_SOLID_W-1:0] EVEN_COLS     = {32{2'b01}};
    localparam logic [ROW_SOLID_W-1:0] ODD_COLS      = {32{2'b10}};

    logic clk;
    logic rst_n;

    srrm_cfg_if cfg_bus ();
    srrm_row_if row_bus ();
    srrm_box_if box_bus ();

    solid_run_rectangle_merger_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_row   (row_bus),
        .o_box   (box_bus)
    );

    // merger state as predicted
    logic [ROW_WIDTH_W-1:0] width_reg;
    logic [ROW_SOLID_W-1:0] stored_row;
    logic [ROW_OUT_W-1:0]   box_top_mem [DEF_MAX_COLUMNS];
    logic [ROW_OUT_W-1:0]   next_row_idx;
    logic [ROW_OUT_W-1:0]   stored_row_idx;

    t_box                   pending_boxes [$];
    int                     mismatches;
    int                     send_idle_pct;
    int                     stall_pct;
    int                     hold_left;
    logic [ROW_SOLID_W-1:0] last_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic run_starts(input logic [ROW_SOLID_W-1:0] bits, input int s);
        if (!bits[s]) return 1'b0;
        if (s == 0) return 1'b1;
        return !bits[s-1];
    endfunction

    function automatic int run_end(input logic [ROW_SOLID_W-1:0] bits, input int s);
        int e;
        e = s;
        while (e < ROW_SOLID_W - 1 && bits[e+1]) e++;
        return e;
    endfunction

    function automatic t_box make_box(input int l, input int r, input logic [ROW_OUT_W-1:0] top,
                                      input logic [ROW_OUT_W-1:0] bottom);
        t_box b;
        b.box_left   = COL_OUT_W'(l);
        b.box_right  = COL_OUT_W'(r);
        b.box_top    = top;
        b.box_bottom = bottom;
        b.last_box   = 1'b0;
        return b;
    endfunction

    function automatic void predict_merge(input logic [ROW_SOLID_W-1:0] solid,
                                          input logic last_row);
        int                     w;
        int                     e;
        logic [ROW_SOLID_W-1:0] cur;
        logic [ROW_SOLID_W-1:0] prev;
        t_box                   step_boxes [$];
        prev = stored_row;
        w = (width_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(width_reg);
        cur = (w >= ROW_SOLID_W) ? ALL_SOLID : ((64'd1 << w) - 64'd1);
        cur = cur & solid;
        // previous boxes not repeated exactly are closed
        for (int s = 0; s < ROW_SOLID_W; s++) begin
            if (run_starts(prev, s)) begin
                e = run_end(prev, s);
                if (!(run_starts(cur, s) && run_end(cur, s) == e))
                    step_boxes = {step_boxes, make_box(s, e, box_top_mem[s], stored_row_idx)};
            end
        end
        for (int s = 0; s < ROW_SOLID_W; s++) begin
            if (run_starts(cur, s) &&
                !(run_starts(prev, s) && run_end(prev, s) == run_end(cur, s)))
                box_top_mem[s] = next_row_idx;
        end
        if (last_row) begin
            for (int s = 0; s < ROW_SOLID_W; s++) begin
                if (run_starts(cur, s))
                    step_boxes = {step_boxes,
                                  make_box(s, run_end(cur, s), box_top_mem[s], next_row_idx)};
            end
            stored_row     = '0;
            next_row_idx   = '0;
            stored_row_idx = '0;
        end else begin
            stored_row     = cur;
            stored_row_idx = next_row_idx;
            if (next_row_idx != ROW_INDEX_TOP) next_row_idx = next_row_idx + 1'b1;
        end
        if (step_boxes.size() > 0) step_boxes[step_boxes.size()-1].last_box = 1'b1;
        pending_boxes = {pending_boxes, step_boxes};
    endfunction

    function automatic void flag_mismatch(input string what, input t_box want, input t_box got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%0t %s: expected l=%0d r=%0d t=%0d b=%0d last=%0b, ",
                      "got l=%0d r=%0d t=%0d b=%0d last=%0b"},
                     $time, what, want.box_left, want.box_right, want.box_top, want.box_bottom,
                     want.last_box, got.box_left, got.box_right, got.box_top, got.box_bottom,
                     got.last_box);
    endfunction

    function automatic logic [ROW_SOLID_W-1:0] random_row(input logic [ROW_SOLID_W-1:0] base);
        logic [ROW_SOLID_W-1:0] bits;
        int                     col;
        int                     len;
        int                     k;
        case ($urandom_range(9)) inside
            [0:3]: bits = base;
            [4:5]: begin
                bits = base;
                repeat ($urandom_range(3, 1)) begin
                    k = $urandom_range(63);
                    bits[k] = ~bits[k];
                end
            end
            [6:7]: begin
                bits = '0;
                col = $urandom_range(7);
                while (col < ROW_SOLID_W) begin
                    len = $urandom_range(12, 1);
                    for (k = col; k < col + len && k < ROW_SOLID_W; k++) bits[k] = 1'b1;
                    col = col + len + $urandom_range(8, 1);
                end
            end
            8: bits = {$urandom, $urandom};
            default: bits = $urandom_range(1) ? ALL_SOLID : '0;
        endcase
        return bits;
    endfunction

    // box checker and receiver ready
    initial begin
        t_box got;
        t_box want;
        box_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (box_bus.valid && box_bus.ready) begin
                got.box_left   = box_bus.box_left;
                got.box_right  = box_bus.box_right;
                got.box_top    = box_bus.box_top;
                got.box_bottom = box_bus.box_bottom;
                got.last_box   = box_bus.last_box;
                if (pending_boxes.size() == 0) begin
                    flag_mismatch("unexpected box", got, got);
                end else begin
                    want = pending_boxes.pop_front();
                    if (got.box_left !== want.box_left || got.box_right !== want.box_right ||
                        got.box_top !== want.box_top || got.box_bottom !== want.box_bottom ||
                        got.last_box !== want.last_box)
                        flag_mismatch("box mismatch", want, got);
                end
            end
            if (hold_left > 0) begin
                box_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                box_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog on cycles with no request moving
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((row_bus.valid && row_bus.ready) || (box_bus.valid && box_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_row(input logic [ROW_SOLID_W-1:0] solid, input logic last_row);
        while ($urandom_range(99) < send_idle_pct) begin
            row_bus.valid <= 1'b0;
            @(posedge clk);
        end
        row_bus.valid     <= 1'b1;
        row_bus.row_solid <= solid;
        row_bus.last_row  <= last_row;
        @(posedge clk);
        while (!row_bus.ready) @(posedge clk);
        predict_merge(solid, last_row);
        last_sent = solid;
    endtask

    task automatic settle_block();
        row_bus.valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [ROW_WIDTH_W-1:0] value);
        settle_block();
        cfg_bus.valid     <= 1'b1;
        cfg_bus.row_width <= value;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        width_reg = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [ROW_WIDTH_W-1:0] width, input int idle_pct,
                                    input int stall, input int count);
        write_width(width);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count) send_row(random_row(last_sent), $urandom_range(7) == 0);
        settle_block();
    endtask

    task automatic test_directed_rows();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_row('0, 1'b0);
        send_row(ALL_SOLID, 1'b0);
        send_row(ALL_SOLID, 1'b0);
        send_row(EVEN_COLS, 1'b0);
        // closes every even column box and emits every odd one
        send_row(ODD_COLS, 1'b1);
        send_row('0, 1'b1);
        send_row(64'h00F0, 1'b0);
        send_row(64'h01F0, 1'b0);
        send_row(64'h01F8, 1'b0);
        send_row(64'h01F8, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        settle_block();
    endtask

    task automatic test_width_settings();
        write_width(7'd0);
        send_row(ALL_SOLID, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        write_width(7'd127);
        send_row(ALL_SOLID, 1'b0);
        send_row(ALL_SOLID, 1'b1);
        write_width(7'd1);
        send_row(ALL_SOLID, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h1, 1'b1);
        write_width(7'd63);
        send_row(ALL_SOLID, 1'b0);
        send_row(ALL_SOLID, 1'b1);
        // width narrowed while a map is open
        write_width(7'd65);
        send_row(ALL_SOLID, 1'b0);
        write_width(7'd8);
        send_row(ALL_SOLID, 1'b0);
        send_row(ALL_SOLID, 1'b1);
        write_width(7'd64);
    endtask

    task automatic test_random_traffic();
        run_random_phase(7'd64, 0, 0, 20);
        run_random_phase(ROW_WIDTH_W'($urandom_range(63, 2)), 73, 0, 20);
        run_random_phase(7'd127, 0, 73, 20);
        run_random_phase(ROW_WIDTH_W'($urandom_range(64, 1)), 11, 11, 20);
    endtask

    task automatic test_output_hold_off();
        write_width(7'd64);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        send_row(EVEN_COLS, 1'b0);
        send_row(ODD_COLS, 1'b0);
        send_row(EVEN_COLS, 1'b0);
        send_row(ODD_COLS, 1'b1);
        repeat (6) send_row(random_row(last_sent), $urandom_range(3) == 0);
        send_row(EVEN_COLS, 1'b1);
        settle_block();
    endtask

    initial begin
        rst_n             <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.row_width <= ROW_WIDTH_RESET;
        row_bus.valid     <= 1'b0;
        row_bus.row_solid <= '0;
        row_bus.last_row  <= 1'b0;
        width_reg      = ROW_WIDTH_RESET;
        stored_row     = '0;
        next_row_idx   = '0;
        stored_row_idx = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;
        last_sent      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_rows();
        test_width_settings();
        test_random_traffic();
        test_output_hold_off();
        settle_block();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/srrm_pkg.sv
sv/srrm_if.sv
sv/srrm_lane.sv
sv/srrm_merge.sv
sv/solid_run_rectangle_merger_top.sv
bench/testbench.sv
